FILE: sv/fcr_pkg.sv
// Package for the framed code receiver: transaction structs, configuration
// struct, mode, status and error codes, and sizing constants.
// Depends on nothing; every other file imports it.
package fcr_pkg;

    localparam int PAYLOAD_CHARS = 4;

    localparam logic [3:0]  COUNT_MAX    = 4'd15;
    localparam logic [3:0]  PAYLOAD_CNT  = 4'(PAYLOAD_CHARS);
    localparam logic [7:0]  CODE_CR      = 8'h0D;
    localparam logic [7:0]  CODE_CAN     = 8'h18;
    localparam logic [15:0] INVALID_CODE = 16'hFFFF;

    localparam logic [15:0] TIMEOUT_RESET = 16'd500;
    localparam logic [7:0]  START_RESET   = 8'h02;
    localparam logic [7:0]  END_RESET     = 8'h0A;

    localparam int ADDR_W = 4;

    typedef enum logic [1:0] {
        MODE_ARM  = 2'd0,
        MODE_BYTE = 2'd1,
        MODE_TICK = 2'd2,
        MODE_NONE = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        REG_TIMEOUT = 2'd0,
        REG_START   = 2'd1,
        REG_END     = 2'd2,
        REG_SPARE   = 2'd3
    } reg_idx_t;

    localparam logic [1:0] STATUS_DONE  = 2'd0;
    localparam logic [1:0] STATUS_BUSY  = 2'd1;
    localparam logic [1:0] STATUS_ERROR = 2'd2;

    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_LINE    = 2'd1;
    localparam logic [1:0] ERR_TIMEOUT = 2'd2;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] rx_byte;
        logic       line_error;
    } fcr_in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [1:0]  error_kind;
        logic [15:0] code_value;
        logic        scan_off;
    } fcr_out_t;

    typedef struct packed {
        logic [15:0] timeout_ticks;
        logic [7:0]  frame_start_byte;
        logic [7:0]  frame_end_byte;
    } fcr_cfg_t;

endpackage

FILE: sv/fcr_cfg_regs.sv
// Configuration register file of the framed code receiver on an APB-style port.
// Depends on fcr_pkg for the register indexes, reset values and config struct.
module fcr_cfg_regs (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [fcr_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    output fcr_pkg::fcr_cfg_t         cfg
);
    import fcr_pkg::*;

    logic [15:0] timeout_ticks_reg;
    logic [7:0]  frame_start_byte_reg;
    logic [7:0]  frame_end_byte_reg;
    logic        wr_en;
    reg_idx_t    idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign idx    = reg_idx_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_ticks_reg    <= TIMEOUT_RESET;
            frame_start_byte_reg <= START_RESET;
            frame_end_byte_reg   <= END_RESET;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_TIMEOUT: timeout_ticks_reg    <= pwdata[15:0];
                REG_START:   frame_start_byte_reg <= pwdata[7:0];
                REG_END:     frame_end_byte_reg   <= pwdata[7:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_TIMEOUT: prdata = {16'd0, timeout_ticks_reg};
            REG_START:   prdata = {24'd0, frame_start_byte_reg};
            REG_END:     prdata = {24'd0, frame_end_byte_reg};
            default:     prdata = 32'd0;
        endcase
    end

    assign cfg.timeout_ticks    = timeout_ticks_reg;
    assign cfg.frame_start_byte = frame_start_byte_reg;
    assign cfg.frame_end_byte   = frame_end_byte_reg;

endmodule

FILE: sv/fcr_core.sv
// Receiver state, single-pass next-state and result logic, and result register.
// Depends on fcr_pkg for the transaction structs, codes and constants.
module fcr_core (
    input  logic               clk,
    input  logic               rst_n,
    input  fcr_pkg::fcr_cfg_t  cfg,
    input  logic               in_valid,
    output logic               in_ready,
    input  fcr_pkg::fcr_in_t   in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output fcr_pkg::fcr_out_t  out_data
);
    import fcr_pkg::*;

    logic        armed_reg, armed_next;
    logic        in_frame_reg, in_frame_next;
    logic [3:0]  char_count_reg, char_count_next;
    logic [13:0] running_value_reg, running_value_next;
    logic        digits_stopped_reg, digits_stopped_next;
    logic [15:0] ticks_left_reg, ticks_left_next;
    logic        out_valid_reg;
    fcr_out_t    out_data_reg, out_data_next;

    logic        accept;
    logic        is_digit;
    logic        is_payload;
    logic [15:0] ticks_dec;
    logic [3:0]  digit;
    logic        disarm;

    assign in_ready = ~out_valid_reg | out_ready;
    assign accept   = in_valid & in_ready;
    assign is_digit = in_data.rx_byte inside {[8'h30:8'h39]};
    assign digit    = in_data.rx_byte[3:0];
    assign is_payload = (in_data.rx_byte != cfg.frame_end_byte)
                      && (in_data.rx_byte != CODE_CR)
                      && (in_data.rx_byte != CODE_CAN);
    assign ticks_dec = ticks_left_reg - {15'd0, (ticks_left_reg != 16'd0)};

    always_comb
    begin
        armed_next          = armed_reg;
        in_frame_next       = in_frame_reg;
        char_count_next     = char_count_reg;
        running_value_next  = running_value_reg;
        digits_stopped_next = digits_stopped_reg;
        ticks_left_next     = ticks_left_reg;
        disarm              = 1'b0;
        out_data_next       = '{status: STATUS_BUSY, error_kind: ERR_NONE,
                                code_value: 16'd0, scan_off: 1'b0};

        case (mode_t'(in_data.mode))
            MODE_ARM:
            begin
                disarm = 1'b1;
            end
            MODE_BYTE:
            begin
                if (armed_reg)
                begin
                    if (in_data.line_error)
                    begin
                        disarm = 1'b1;
                        out_data_next = '{status: STATUS_ERROR, error_kind: ERR_LINE,
                                          code_value: INVALID_CODE, scan_off: 1'b0};
                    end
                    else if (in_data.rx_byte == cfg.frame_end_byte
                             && char_count_reg == PAYLOAD_CNT)
                    begin
                        disarm = 1'b1;
                        out_data_next = '{status: STATUS_DONE, error_kind: ERR_NONE,
                                          code_value: {2'd0, running_value_reg},
                                          scan_off: 1'b0};
                    end
                    else
                    begin
                        if (in_data.rx_byte == cfg.frame_end_byte)
                        begin
                            in_frame_next = 1'b0;
                            if (char_count_reg > PAYLOAD_CNT)
                            begin
                                char_count_next     = 4'd0;
                                running_value_next  = 14'd0;
                                digits_stopped_next = 1'b0;
                            end
                        end
                        if (in_frame_reg && in_data.rx_byte != cfg.frame_end_byte)
                        begin
                            if (in_data.rx_byte == cfg.frame_start_byte)
                            begin
                                char_count_next     = 4'd0;
                                running_value_next  = 14'd0;
                                digits_stopped_next = 1'b0;
                            end
                            else if (is_payload)
                            begin
                                if (char_count_reg < PAYLOAD_CNT && !digits_stopped_reg)
                                begin
                                    if (is_digit)
                                    begin
                                        running_value_next = (running_value_reg << 3)
                                            + (running_value_reg << 1) + {10'd0, digit};
                                    end
                                    else
                                    begin
                                        digits_stopped_next = 1'b1;
                                    end
                                end
                                if (char_count_reg < COUNT_MAX)
                                begin
                                    char_count_next = char_count_reg + 4'd1;
                                end
                            end
                        end
                        else if (in_data.rx_byte == cfg.frame_start_byte)
                        begin
                            in_frame_next       = 1'b1;
                            char_count_next     = 4'd0;
                            running_value_next  = 14'd0;
                            digits_stopped_next = 1'b0;
                        end
                    end
                end
            end
            MODE_TICK:
            begin
                if (armed_reg)
                begin
                    if (ticks_dec == 16'd0)
                    begin
                        disarm = 1'b1;
                        out_data_next = '{status: STATUS_ERROR, error_kind: ERR_TIMEOUT,
                                          code_value: INVALID_CODE, scan_off: 1'b1};
                    end
                    else
                    begin
                        ticks_left_next = ticks_dec;
                    end
                end
            end
            default: ;
        endcase

        if (disarm)
        begin
            armed_next          = 1'b0;
            in_frame_next       = 1'b0;
            char_count_next     = 4'd0;
            running_value_next  = 14'd0;
            digits_stopped_next = 1'b0;
            ticks_left_next     = 16'd0;
        end
        if (mode_t'(in_data.mode) == MODE_ARM)
        begin
            armed_next      = 1'b1;
            ticks_left_next = cfg.timeout_ticks;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg          <= 1'b0;
            in_frame_reg       <= 1'b0;
            char_count_reg     <= 4'd0;
            running_value_reg  <= 14'd0;
            digits_stopped_reg <= 1'b0;
            ticks_left_reg     <= 16'd0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                armed_reg          <= armed_next;
                in_frame_reg       <= in_frame_next;
                char_count_reg     <= char_count_next;
                running_value_reg  <= running_value_next;
                digits_stopped_reg <= digits_stopped_next;
                ticks_left_reg     <= ticks_left_next;
                out_valid_reg      <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

FILE: sv/framed_code_receiver.sv
// Top level of the framed code receiver: configuration port and receiver core.
// Depends on fcr_pkg, fcr_cfg_regs and fcr_core.
//
// Each input transaction (arm, received byte, timer tick or none) yields exactly one
// result transaction, which appears in the result register in the cycle after
// acceptance; a new input transaction is accepted in every cycle in which the
// result register is empty or being emptied, so one transaction per cycle is
// sustained while out_ready stays high. A done result carries the decimal
// code, an error result carries 65535, and a timeout result also raises
// scan_off.
module framed_code_receiver (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [fcr_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  fcr_pkg::fcr_in_t           in_data,
    output logic                       out_valid,
    input  logic                       out_ready,
    output fcr_pkg::fcr_out_t          out_data
);
    import fcr_pkg::*;

    fcr_cfg_t cfg;

    fcr_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    fcr_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

FILE: verif/tb_framed_code_receiver.sv
// Self-checking testbench for framed_code_receiver: directed and random byte streams,
// with APB register writes between phases and random idling on both channels.
// Depends on fcr_pkg and the framed_code_receiver RTL.
module tb_framed_code_receiver;
    timeunit 1ns;
    timeprecision 1ps;

    import fcr_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    logic                clk;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;
    logic                in_valid;
    logic                in_ready;
    fcr_in_t             in_data;
    logic                out_valid;
    logic                out_ready;
    fcr_out_t            out_data;

    fcr_out_t            pending_replies[$];
    fcr_out_t            oldest_reply;
    fcr_cfg_t            cfg;

    logic                rx_armed;
    logic                rx_in_frame;
    logic [3:0]          rx_count;
    logic [13:0]         rx_value;
    logic                rx_stopped;
    logic [15:0]         rx_ticks;

    bit                  idle_on;
    int                  tick_pct;
    int                  items_sent;
    int                  mismatches;
    int                  cycles;

    framed_code_receiver i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_framed_code_receiver: FAIL");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        out_ready <= !idle_on || ($urandom_range(99) >= 17);
    end

    task automatic note_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch in %s: expected %0h, got %0h", what, want, got);
    endtask

    always @(negedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_replies.size() == 0)
                note_mismatch("unexpected result", 32'h0, 32'(out_data));
            else
            begin
                oldest_reply = pending_replies.pop_front();
                if (out_data.status !== oldest_reply.status)
                    note_mismatch("status", 32'(oldest_reply.status),
                                  32'(out_data.status));
                if (out_data.error_kind !== oldest_reply.error_kind)
                    note_mismatch("error_kind", 32'(oldest_reply.error_kind),
                                  32'(out_data.error_kind));
                if (out_data.code_value !== oldest_reply.code_value)
                    note_mismatch("code_value", 32'(oldest_reply.code_value),
                                  32'(out_data.code_value));
                if (out_data.scan_off !== oldest_reply.scan_off)
                    note_mismatch("scan_off", 32'(oldest_reply.scan_off),
                                  32'(out_data.scan_off));
            end
        end
    end

    task automatic clear_payload();
        rx_count   = 4'd0;
        rx_value   = 14'd0;
        rx_stopped = 1'b0;
    endtask

    task automatic disarm_receiver();
        rx_armed    = 1'b0;
        rx_in_frame = 1'b0;
        clear_payload();
        rx_ticks    = 16'd0;
    endtask

    task automatic advance_receiver(input fcr_in_t it, output fcr_out_t reply);
        logic finished;
        finished = 1'b0;
        reply = '{status: STATUS_BUSY, error_kind: ERR_NONE, code_value: 16'd0,
                  scan_off: 1'b0};
        if (it.mode == MODE_ARM)
        begin
            disarm_receiver();
            rx_armed = 1'b1;
            rx_ticks = cfg.timeout_ticks;
        end
        else if (!rx_armed || it.mode == MODE_NONE)
        begin
            finished = 1'b1;
        end
        else if (it.mode == MODE_TICK)
        begin
            if (rx_ticks != 16'd0)
                rx_ticks = rx_ticks - 16'd1;
            if (rx_ticks == 16'd0)
            begin
                disarm_receiver();
                reply = '{status: STATUS_ERROR, error_kind: ERR_TIMEOUT,
                          code_value: INVALID_CODE, scan_off: 1'b1};
            end
        end
        else if (it.line_error)
        begin
            disarm_receiver();
            reply = '{status: STATUS_ERROR, error_kind: ERR_LINE,
                      code_value: INVALID_CODE, scan_off: 1'b0};
        end
        else
        begin
            if (it.rx_byte == cfg.frame_end_byte)
            begin
                rx_in_frame = 1'b0;
                if (rx_count == PAYLOAD_CNT)
                begin
                    reply.status     = STATUS_DONE;
                    reply.code_value = {2'b00, rx_value};
                    disarm_receiver();
                    finished = 1'b1;
                end
                else if (rx_count > PAYLOAD_CNT)
                    clear_payload();
            end
            if (!finished)
            begin
                if (rx_in_frame)
                begin
                    if (it.rx_byte == cfg.frame_start_byte)
                        clear_payload();
                    else if (it.rx_byte != cfg.frame_end_byte && it.rx_byte != CODE_CR &&
                             it.rx_byte != CODE_CAN)
                    begin
                        if (rx_count < PAYLOAD_CNT && !rx_stopped)
                        begin
                            if (it.rx_byte >= 8'h30 && it.rx_byte <= 8'h39)
                                rx_value = 14'(rx_value * 10 + (it.rx_byte - 8'h30));
                            else
                                rx_stopped = 1'b1;
                        end
                        if (rx_count < COUNT_MAX)
                            rx_count = rx_count + 4'd1;
                    end
                end
                else if (it.rx_byte == cfg.frame_start_byte)
                begin
                    rx_in_frame = 1'b1;
                    clear_payload();
                end
            end
        end
    endtask

    function automatic fcr_in_t make_item(input logic [1:0] mode, input logic [7:0] b,
                                          input logic lerr);
        fcr_in_t it;
        it.mode       = mode;
        it.rx_byte    = b;
        it.line_error = lerr;
        return it;
    endfunction

    task automatic send_item(input fcr_in_t item);
        fcr_out_t reply;
        bit       taken;
        if (idle_on)
        begin
            while ($urandom_range(99) < 17)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        in_data  <= item;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = in_ready;
            if (taken)
            begin
                advance_receiver(item, reply);
                pending_replies.push_back(reply);
            end
            @(posedge clk);
        end
        items_sent++;
    endtask

    task automatic send_rx(input logic [7:0] b);
        send_item(make_item(MODE_BYTE, b, 1'b0));
    endtask

    task automatic wait_quiet();
        in_valid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
        logic [31:0] mask;
        mask = (idx == REG_TIMEOUT) ? 32'h0000_FFFF : 32'h0000_00FF;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value & mask;
        @(posedge clk);
        penable <= 1'b1;
        do @(negedge clk); while (!pready);
        @(posedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(negedge clk); while (!pready);
        if (prdata !== (value & mask))
            note_mismatch("register readback", value & mask, prdata);
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_TIMEOUT: cfg.timeout_ticks    = value[15:0];
            REG_START:   cfg.frame_start_byte = value[7:0];
            REG_END:     cfg.frame_end_byte   = value[7:0];
            default:     ;
        endcase
    endtask

    task automatic configure(input logic [15:0] ticks, input logic [7:0] start_b,
                             input logic [7:0] end_b);
        wait_quiet();
        write_reg(REG_TIMEOUT, {16'd0, ticks});
        write_reg(REG_START, {24'd0, start_b});
        write_reg(REG_END, {24'd0, end_b});
    endtask

    task automatic send_random_frame();
        int          n;
        int          r;
        logic [7:0]  b;
        if ($urandom_range(3) != 0)
            send_item(make_item(MODE_ARM, 8'($urandom), 1'($urandom_range(1))));
        if ($urandom_range(4) == 0)
            send_rx(8'($urandom));
        send_rx(cfg.frame_start_byte);
        if ($urandom_range(19) == 0)
            n = $urandom_range(14, 18);
        else if ($urandom_range(3) == 0)
            n = $urandom_range(0, 7);
        else
            n = PAYLOAD_CHARS;
        for (int k = 0; k < n; k++)
        begin
            if ($urandom_range(99) < tick_pct)
                send_item(make_item(MODE_TICK, 8'($urandom), 1'($urandom_range(1))));
            r = $urandom_range(99);
            if (r < 80)
                b = 8'h30 + 8'($urandom_range(9));
            else if (r < 85)
                b = CODE_CR;
            else if (r < 90)
                b = CODE_CAN;
            else
                b = 8'($urandom);
            send_item(make_item(MODE_BYTE, b, $urandom_range(99) < 2));
        end
        send_rx(cfg.frame_end_byte);
    endtask

    task automatic run_random(input int count);
        int target;
        target = items_sent + count;
        while (items_sent < target)
        begin
            if ($urandom_range(99) < 75)
                send_random_frame();
            else
                repeat ($urandom_range(1, 3))
                    send_item(make_item(2'($urandom_range(3)), 8'($urandom),
                                        1'($urandom_range(1))));
        end
    endtask

    task automatic test_idle_ignored();
        send_item(make_item(MODE_BYTE, 8'h00, 1'b1));
        send_item(make_item(MODE_TICK, 8'h00, 1'b0));
        send_item(make_item(MODE_NONE, 8'hFF, 1'b1));
    endtask

    task automatic test_decimal_frame();
        send_item(make_item(MODE_ARM, 8'h00, 1'b0));
        send_item(make_item(MODE_ARM, 8'hFF, 1'b1));
        send_rx(START_RESET);
        repeat (4) send_rx("9");
        send_rx(END_RESET);
    endtask

    task automatic test_short_frame_and_stop();
        send_item(make_item(MODE_ARM, 8'h00, 1'b0));
        send_rx(START_RESET);
        send_rx("1");
        send_rx(END_RESET);
        send_rx(START_RESET);
        send_rx("5");
        send_rx("x");
        send_rx("7");
        send_rx("8");
        send_rx(END_RESET);
    endtask

    task automatic test_line_error();
        send_item(make_item(MODE_ARM, 8'h00, 1'b0));
        send_item(make_item(MODE_BYTE, "3", 1'b1));
    endtask

    task automatic test_timeout();
        configure(16'd2, START_RESET, END_RESET);
        send_item(make_item(MODE_ARM, 8'h00, 1'b0));
        send_item(make_item(MODE_TICK, 8'h00, 1'b1));
        send_item(make_item(MODE_TICK, 8'hFF, 1'b0));
        configure(16'd0, START_RESET, END_RESET);
        send_item(make_item(MODE_ARM, 8'h00, 1'b0));
        send_item(make_item(MODE_TICK, 8'h00, 1'b0));
    endtask

    task automatic test_random_default_delimiters();
        configure(TIMEOUT_RESET, START_RESET, END_RESET);
        tick_pct = 5;
        run_random(180);
    endtask

    task automatic test_random_short_timeout();
        configure(16'd9, "A", CODE_CR);
        tick_pct = 15;
        run_random(150);
    endtask

    task automatic test_random_shared_delimiter();
        configure(16'hFFFF, 8'h7E, 8'h7E);
        idle_on  = 1'b0;
        tick_pct = 5;
        run_random(150);
        idle_on  = 1'b1;
    endtask

    task automatic test_random_extreme_delimiters();
        configure(16'd1, 8'h00, 8'hFF);
        tick_pct = 3;
        run_random(100);
        configure(16'd40, 8'hFF, 8'h00);
        tick_pct = 8;
        run_random(70);
    endtask

    initial
    begin
        mismatches  = 0;
        items_sent  = 0;
        idle_on     = 1'b1;
        tick_pct    = 5;
        cfg         = '{timeout_ticks: TIMEOUT_RESET, frame_start_byte: START_RESET,
                        frame_end_byte: END_RESET};
        disarm_receiver();
        rst_n     <= 1'b0;
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        paddr     <= '0;
        pwdata    <= 32'd0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        out_ready <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_idle_ignored();
        test_decimal_frame();
        test_short_frame_and_stop();
        test_line_error();
        test_timeout();
        test_random_default_delimiters();
        test_random_short_timeout();
        test_random_shared_delimiter();
        test_random_extreme_delimiters();

        wait_quiet();
        if (mismatches == 0)
            $display("tb_framed_code_receiver: PASS");
        else
            $display("tb_framed_code_receiver: FAIL");
        $finish;
    end

endmodule

FILE: filelist.f
sv/fcr_pkg.sv
sv/fcr_cfg_regs.sv
sv/fcr_core.sv
sv/framed_code_receiver.sv
verif/tb_framed_code_receiver.sv
